// File: hdl/rldm_pkg.sv
// Shared types, codes and default sizes for the resource lock manager.
`default_nettype none
package rldm_pkg;

   localparam int RLDM_NUM_RESOURCES = 16;
   localparam int RLDM_QUEUE_DEPTH   = 8;
   localparam int RLDM_PID_BITS      = 8;

   localparam int CMD_W    = 2;
   localparam int PID_W    = 8;
   localparam int RES_W    = 4;
   localparam int STATUS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOCK    = 2'd0,
      CMD_UNLOCK  = 2'd1,
      CMD_CHECK   = 2'd2,
      CMD_IGNORED = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_GRANTED    = 3'd0,
      STAT_HELD       = 3'd1,
      STAT_QUEUED     = 3'd2,
      STAT_RELEASED   = 3'd3,
      STAT_UNKNOWN    = 3'd4,
      STAT_NOT_HOLDER = 3'd5,
      STAT_QUEUE_FULL = 3'd6
   } status_type;

endpackage
`default_nettype wire

// File: hdl/rldm_if.sv
// Request and response channel interfaces of the resource lock manager.
`default_nettype none
interface rldm_req_if import rldm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [PID_W-1:0]    pid;
   logic [RES_W-1:0]    resource;

   modport source (output valid, command, pid, resource, input ready);
   modport sink   (input valid, command, pid, resource, output ready);
endinterface

interface rldm_rsp_if import rldm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                ok;
   logic [STATUS_W-1:0] status;
   logic                deadlock;
   logic                handoff_valid;
   logic [PID_W-1:0]    handoff_pid;

   modport source (output valid, ok, status, deadlock, handoff_valid, handoff_pid,
                   input ready);
   modport sink   (input valid, ok, status, deadlock, handoff_valid, handoff_pid,
                   output ready);
endinterface
`default_nettype wire

// File: hdl/rldm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rldm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: hdl/resource_lock_deadlock_manager_core.sv
// Lock manager for indexed resources with FIFO waiters and wait-for cycle detection.
//
//   channel | dir | handshake   | payload
//   req     | in  | valid/ready | command, pid, resource
//   rsp     | out | valid/ready | ok, status, deadlock, handoff_valid, handoff_pid
//
// One request at a time. Answers without a waiter read or a scan pass from accept
// through S_EXEC and S_RESP to the response register; an unlock with handoff also
// passes S_UNLK (one waiter RAM read). Queued, queue-full and check requests run the
// deadlock scan: rounds over the NUM_RESOURCES*QUEUE_DEPTH waiter RAM entries (one
// entry per cycle), at most NUM_RESOURCES rounds, ending early once none drops out.
// Synchronous reset; no clearing pass, the block takes requests right after reset.
// A request is taken while a previous response still waits for rsp ready.
`default_nettype none
module resource_lock_deadlock_manager_core import rldm_pkg::*; #(
   parameter int NUM_RESOURCES = RLDM_NUM_RESOURCES,
   parameter int QUEUE_DEPTH   = RLDM_QUEUE_DEPTH,
   parameter int PID_BITS      = RLDM_PID_BITS
) (
   input wire logic   clock,
   input wire logic   reset,
   rldm_req_if.sink   req_chan,
   rldm_rsp_if.source rsp_chan
);

   localparam int N   = NUM_RESOURCES;
   localparam int Q   = QUEUE_DEPTH;
   localparam int TOT = N * Q;
   localparam int RW  = (N > 1) ? $clog2(N) : 1;
   localparam int QW  = (Q > 1) ? $clog2(Q) : 1;
   localparam int CW  = $clog2(Q + 1);
   localparam int AW  = (TOT > 1) ? $clog2(TOT) : 1;
   localparam int IW  = $clog2(TOT + 1);
   localparam int OW  = QW + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_UNLK, S_SCAN, S_RESP
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [PID_BITS-1:0]  pid_ff, pid_in;
   logic [RES_W-1:0]     res_ff, res_in;

   logic                 known_ff [N];
   logic                 known_in [N];
   logic                 busy_ff  [N];
   logic                 busy_in  [N];
   logic [PID_BITS-1:0]  holder_ff [N];
   logic [PID_BITS-1:0]  holder_in [N];
   logic [QW-1:0]        head_ff  [N];
   logic [QW-1:0]        head_in  [N];
   logic [CW-1:0]        count_ff [N];
   logic [CW-1:0]        count_in [N];

   logic [N-1:0]         alive_ff, alive_in;
   logic [N-1:0]         acc_ff, acc_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [RW-1:0]        s_ff, s_in;
   logic [QW-1:0]        j_ff, j_in;
   logic                 pv_ff, pv_in;
   logic [RW-1:0]        ps_ff, ps_in;
   logic [QW-1:0]        pj_ff, pj_in;

   logic                 r_ok_ff, r_ok_in;
   status_type           r_status_ff, r_status_in;
   logic                 r_dl_ff, r_dl_in;
   logic                 r_hv_ff, r_hv_in;
   logic [PID_W-1:0]     r_hp_ff, r_hp_in;

   logic                 o_valid_ff, o_valid_in;
   logic                 o_ok_ff, o_ok_in;
   status_type           o_status_ff, o_status_in;
   logic                 o_dl_ff, o_dl_in;
   logic                 o_hv_ff, o_hv_in;
   logic [PID_W-1:0]     o_hp_ff, o_hp_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [AW-1:0]        ram_raddr;
   logic [PID_BITS-1:0]  ram_rdata;

   logic                 in_range;
   logic [RW-1:0]        ri;
   logic [AW-1:0]        base_addr;
   logic [OW-1:0]        tail_sum;
   logic [QW-1:0]        tail_slot;
   logic [QW-1:0]        head_next;
   logic [OW-1:0]        scan_off;
   logic                 ent_ok;
   logic [N-1:0]         hit;
   logic [N-1:0]         new_alive;

   rldm_ram #(.WIDTH(PID_BITS), .DEPTH(TOT)) u_waiters (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (pid_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign in_range  = int'(res_ff) < N;
   assign ri        = RW'(res_ff);
   assign base_addr = AW'(int'(ri) * Q);

   // next free slot of the circular queue
   always_comb begin
      tail_sum = OW'(head_ff[ri]) + OW'(count_ff[ri]);
      if (int'(tail_sum) >= Q) begin
         tail_sum = tail_sum - OW'(Q);
      end
      tail_slot = QW'(tail_sum);
      head_next = (int'(head_ff[ri]) == Q - 1) ? '0 : head_ff[ri] + QW'(1);
   end

   assign ram_we    = (state_ff == S_EXEC) && (cmd_ff == CMD_LOCK) && in_range &&
                      busy_ff[ri] && (holder_ff[ri] != pid_ff) &&
                      (int'(count_ff[ri]) < Q);
   assign ram_waddr = base_addr + AW'(tail_slot);
   assign ram_raddr = (state_ff == S_SCAN) ? idx_ff[AW-1:0] : base_addr + AW'(head_ff[ri]);

   // scan: is the entry read last cycle a live waiter of a still-alive resource
   always_comb begin
      if (pj_ff >= head_ff[ps_ff]) begin
         scan_off = OW'(pj_ff) - OW'(head_ff[ps_ff]);
      end else begin
         scan_off = OW'(pj_ff) + OW'(Q) - OW'(head_ff[ps_ff]);
      end
      ent_ok = pv_ff && alive_ff[ps_ff] && (scan_off < OW'(count_ff[ps_ff]));
      for (int r = 0; r < N; r++) begin
         hit[r] = ent_ok && (holder_ff[r] == ram_rdata);
      end
      new_alive = alive_ff & (acc_ff | hit);
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      pid_in      = pid_ff;
      res_in      = res_ff;
      known_in    = known_ff;
      busy_in     = busy_ff;
      holder_in   = holder_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      alive_in    = alive_ff;
      acc_in      = acc_ff;
      idx_in      = idx_ff;
      s_in        = s_ff;
      j_in        = j_ff;
      pv_in       = 1'b0;
      ps_in       = ps_ff;
      pj_in       = pj_ff;
      r_ok_in     = r_ok_ff;
      r_status_in = r_status_ff;
      r_dl_in     = r_dl_ff;
      r_hv_in     = r_hv_ff;
      r_hp_in     = r_hp_ff;
      o_valid_in  = o_valid_ff && !rsp_chan.ready;
      o_ok_in     = o_ok_ff;
      o_status_in = o_status_ff;
      o_dl_in     = o_dl_ff;
      o_hv_in     = o_hv_ff;
      o_hp_in     = o_hp_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = cmd_type'(req_chan.command);
               pid_in   = PID_BITS'(req_chan.pid);
               res_in   = req_chan.resource;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            r_ok_in     = 1'b0;
            r_status_in = STAT_GRANTED;
            r_dl_in     = 1'b0;
            r_hv_in     = 1'b0;
            r_hp_in     = '0;
            state_in    = S_RESP;
            alive_in    = '0;
            for (int r = 0; r < N; r++) begin
               alive_in[r] = busy_ff[r];
            end
            acc_in = '0;
            idx_in = '0;
            s_in   = '0;
            j_in   = '0;
            case (cmd_ff)
               CMD_LOCK: begin
                  if (!in_range) begin
                     r_status_in = STAT_UNKNOWN;
                  end else if (!busy_ff[ri]) begin
                     known_in[ri]  = 1'b1;
                     busy_in[ri]   = 1'b1;
                     holder_in[ri] = pid_ff;
                     r_ok_in       = 1'b1;
                  end else if (holder_ff[ri] == pid_ff) begin
                     r_ok_in     = 1'b1;
                     r_status_in = STAT_HELD;
                  end else if (int'(count_ff[ri]) >= Q) begin
                     r_status_in = STAT_QUEUE_FULL;
                     state_in    = S_SCAN;
                  end else begin
                     count_in[ri] = count_ff[ri] + CW'(1);
                     r_status_in  = STAT_QUEUED;
                     state_in     = S_SCAN;
                  end
               end
               CMD_UNLOCK: begin
                  if (!in_range || !known_ff[ri]) begin
                     r_status_in = STAT_UNKNOWN;
                  end else if (!busy_ff[ri] || holder_ff[ri] != pid_ff) begin
                     r_status_in = STAT_NOT_HOLDER;
                  end else if (count_ff[ri] == '0) begin
                     busy_in[ri] = 1'b0;
                     r_ok_in     = 1'b1;
                     r_status_in = STAT_RELEASED;
                  end else begin
                     state_in = S_UNLK;
                  end
               end
               CMD_CHECK: begin
                  state_in = S_SCAN;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         S_UNLK: begin
            // oldest waiter takes over; busy stays set
            holder_in[ri] = ram_rdata;
            head_in[ri]   = head_next;
            count_in[ri]  = count_ff[ri] - CW'(1);
            r_ok_in       = 1'b1;
            r_status_in   = STAT_RELEASED;
            r_hv_in       = 1'b1;
            r_hp_in       = PID_W'(ram_rdata);
            state_in      = S_RESP;
         end

         S_SCAN: begin
            acc_in = acc_ff | hit;
            if (int'(idx_ff) < TOT) begin
               pv_in  = 1'b1;
               ps_in  = s_ff;
               pj_in  = j_ff;
               idx_in = idx_ff + IW'(1);
               if (int'(j_ff) == Q - 1) begin
                  j_in = '0;
                  s_in = s_ff + RW'(1);
               end else begin
                  j_in = j_ff + QW'(1);
               end
            end else begin
               // end of a round: drop resources whose holder waits on nothing alive
               if (new_alive == alive_ff || new_alive == '0) begin
                  r_dl_in  = |new_alive;
                  state_in = S_RESP;
               end
               alive_in = new_alive;
               acc_in   = '0;
               idx_in   = '0;
               s_in     = '0;
               j_in     = '0;
            end
         end

         S_RESP: begin
            if (!o_valid_ff || rsp_chan.ready) begin
               o_valid_in  = 1'b1;
               o_ok_in     = r_ok_ff;
               o_status_in = r_status_ff;
               o_dl_in     = r_dl_ff;
               o_hv_in     = r_hv_ff;
               o_hp_in     = r_hp_ff;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pid_ff      <= pid_in;
      res_ff      <= res_in;
      holder_ff   <= holder_in;
      alive_ff    <= alive_in;
      acc_ff      <= acc_in;
      idx_ff      <= idx_in;
      s_ff        <= s_in;
      j_ff        <= j_in;
      ps_ff       <= ps_in;
      pj_ff       <= pj_in;
      r_ok_ff     <= r_ok_in;
      r_status_ff <= r_status_in;
      r_dl_ff     <= r_dl_in;
      r_hv_ff     <= r_hv_in;
      r_hp_ff     <= r_hp_in;
      o_ok_ff     <= o_ok_in;
      o_status_ff <= o_status_in;
      o_dl_ff     <= o_dl_in;
      o_hv_ff     <= o_hv_in;
      o_hp_ff     <= o_hp_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         pv_ff      <= 1'b0;
         o_valid_ff <= 1'b0;
         for (int r = 0; r < N; r++) begin
            known_ff[r] <= 1'b0;
            busy_ff[r]  <= 1'b0;
            head_ff[r]  <= '0;
            count_ff[r] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         pv_ff      <= pv_in;
         o_valid_ff <= o_valid_in;
         known_ff   <= known_in;
         busy_ff    <= busy_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
      end
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = o_valid_ff;
   assign rsp_chan.ok            = o_ok_ff;
   assign rsp_chan.status        = o_status_ff;
   assign rsp_chan.deadlock      = o_dl_ff;
   assign rsp_chan.handoff_valid = o_hv_ff;
   assign rsp_chan.handoff_pid   = o_hp_ff;

endmodule
`default_nettype wire

// File: hdl/rldm_checker.sv
// Port-level checks for the resource lock manager, bound to the top level.
`default_nettype none
module rldm_checker import rldm_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                ok,
   input wire logic [STATUS_W-1:0] status,
   input wire logic                deadlock,
   input wire logic                handoff_valid,
   input wire logic [PID_W-1:0]    handoff_pid
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(handoff_pid))
      else $error("response dropped or changed while stalled");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ok |-> status == STAT_GRANTED || status == STAT_HELD ||
                          status == STAT_RELEASED)
      else $error("ok set with a failing status");

   a_handoff: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && handoff_valid |-> ok && status == STAT_RELEASED)
      else $error("handoff without a successful release");

   a_handoff_pid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !handoff_valid |-> handoff_pid == '0)
      else $error("handoff pid set without handoff");

   a_deadlock: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && deadlock |-> !ok)
      else $error("deadlock reported on a granted request");

endmodule

bind resource_lock_deadlock_manager_core rldm_checker u_rldm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .ok            (rsp_chan.ok),
   .status        (rsp_chan.status),
   .deadlock      (rsp_chan.deadlock),
   .handoff_valid (rsp_chan.handoff_valid),
   .handoff_pid   (rsp_chan.handoff_pid)
);
`default_nettype wire
